FILE: rtl/core/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int unsigned HUE_W   = 9;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned FRAC_W  = 6;
  localparam int unsigned NUM_W   = 14;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned PP_W    = 2 * LEVEL_W;
  localparam int unsigned PQ_W    = LEVEL_W + NUM_W;

  localparam logic [HUE_W-1:0]   HUE_TURN   = 9'd360;
  localparam logic [FRAC_W-1:0]  SECTOR_DEG = 6'd60;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
  localparam logic [NUM_W-1:0]   FRAC_DEN   = 14'd15300;

  // floor(x/255) = (x*RECIP_LEVEL) >> 24 for x < 2^16
  localparam logic [16:0] RECIP_LEVEL = 17'd65794;
  localparam int unsigned RECIP_LEVEL_SH = 24;
  // floor(x/15300) = (x*RECIP_FRAC) >> 36 for x < 2^22
  localparam logic [22:0] RECIP_FRAC = 23'd4491470;
  localparam int unsigned RECIP_FRAC_SH = 36;

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  typedef struct packed {
    sector_t              sector;
    logic [LEVEL_W-1:0]   v;
    logic [LEVEL_W-1:0]   sd;
    logic [NUM_W-1:0]     nq;
    logic [NUM_W-1:0]     nt;
  } hsv2rgb_num_t;

  typedef struct packed {
    sector_t            sector;
    logic [LEVEL_W-1:0] v;
    logic [LEVEL_W-1:0] p;
    logic [LEVEL_W-1:0] q;
    logic [LEVEL_W-1:0] t;
  } hsv2rgb_lvl_t;

endpackage

FILE: rtl/core/hsv2rgb_if.sv
interface hsv2rgb_in_if;
  import hsv2rgb_pkg::*;
  logic               valid;
  logic               ready;
  logic [HUE_W-1:0]   hue_deg;
  logic [LEVEL_W-1:0] sat_level;
  logic [LEVEL_W-1:0] val_level;

  modport source (output valid, output hue_deg, output sat_level, output val_level,
                  input ready);
  modport sink (input valid, input hue_deg, input sat_level, input val_level,
                output ready);
endinterface

interface hsv2rgb_out_if;
  import hsv2rgb_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] rgb565_word;

  modport source (output valid, output rgb565_word, input ready);
  modport sink (input valid, input rgb565_word, output ready);
endinterface

FILE: rtl/core/hsv2rgb_front.sv
module hsv2rgb_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]   hue_deg,
  input  logic [hsv2rgb_pkg::LEVEL_W-1:0] sat_level,
  input  logic [hsv2rgb_pkg::LEVEL_W-1:0] val_level,
  output logic                          num_valid,
  input  logic                          num_ready,
  output hsv2rgb_pkg::hsv2rgb_num_t     num
);
  import hsv2rgb_pkg::*;

  logic [HUE_W-1:0]   hue_red;
  logic [HUE_W-1:0]   base;
  sector_t            sector_c;
  logic [FRAC_W-1:0]  k_c;

  logic               valid1;
  sector_t            sector1;
  logic [FRAC_W-1:0]  k1;
  logic [LEVEL_W-1:0] s1;
  logic [LEVEL_W-1:0] v1;

  logic               rdy1;
  logic               rdy2;
  logic [FRAC_W-1:0]  kc1;
  logic [NUM_W-1:0]   sk;
  logic [NUM_W-1:0]   skc;

  always_comb begin
    hue_red = (hue_deg >= HUE_TURN) ? hue_deg - HUE_TURN : hue_deg;
    if (hue_red < 9'd60) begin
      sector_c = SEC_RED_YEL;
      base     = 9'd0;
    end else if (hue_red < 9'd120) begin
      sector_c = SEC_YEL_GRN;
      base     = 9'd60;
    end else if (hue_red < 9'd180) begin
      sector_c = SEC_GRN_CYN;
      base     = 9'd120;
    end else if (hue_red < 9'd240) begin
      sector_c = SEC_CYN_BLU;
      base     = 9'd180;
    end else if (hue_red < 9'd300) begin
      sector_c = SEC_BLU_MAG;
      base     = 9'd240;
    end else begin
      sector_c = SEC_MAG_RED;
      base     = 9'd300;
    end
    k_c = FRAC_W'(hue_red - base);
  end

  assign rdy2     = !num_valid || num_ready;
  assign rdy1     = !valid1 || rdy2;
  assign up_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (rdy1) begin
      valid1 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      sector1 <= sector_c;
      k1      <= k_c;
      s1      <= sat_level;
      v1      <= val_level;
    end
  end

  assign kc1 = SECTOR_DEG - k1;
  assign sk  = NUM_W'(s1) * NUM_W'(k1);
  assign skc = NUM_W'(s1) * NUM_W'(kc1);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_valid <= 1'b0;
    end else if (rdy2) begin
      num_valid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && valid1) begin
      num.sector <= sector1;
      num.v      <= v1;
      num.sd     <= LEVEL_MAX - s1;
      num.nq     <= FRAC_DEN - sk;
      num.nt     <= FRAC_DEN - skc;
    end
  end

endmodule

FILE: rtl/core/hsv2rgb_div.sv
module hsv2rgb_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      num_valid,
  output logic                      num_ready,
  input  hsv2rgb_pkg::hsv2rgb_num_t num,
  output logic                      lvl_valid,
  input  logic                      lvl_ready,
  output hsv2rgb_pkg::hsv2rgb_lvl_t lvl
);
  import hsv2rgb_pkg::*;

  logic               valid3;
  sector_t            sector3;
  logic [LEVEL_W-1:0] v3;
  logic [PP_W-1:0]    pp3;
  logic [PQ_W-1:0]    pq3;
  logic [PQ_W-1:0]    pt3;

  logic               rdy3;
  logic               rdy4;
  logic [PP_W+16:0]   pp_m;
  logic [PQ_W+22:0]   pq_m;
  logic [PQ_W+22:0]   pt_m;

  assign rdy4      = !lvl_valid || lvl_ready;
  assign rdy3      = !valid3 || rdy4;
  assign num_ready = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (rdy3) begin
      valid3 <= num_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && num_valid) begin
      sector3 <= num.sector;
      v3      <= num.v;
      pp3     <= num.v * num.sd;
      pq3     <= num.v * num.nq;
      pt3     <= num.v * num.nt;
    end
  end

  assign pp_m = pp3 * RECIP_LEVEL;
  assign pq_m = pq3 * RECIP_FRAC;
  assign pt_m = pt3 * RECIP_FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_valid <= 1'b0;
    end else if (rdy4) begin
      lvl_valid <= valid3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && valid3) begin
      lvl.sector <= sector3;
      lvl.v      <= v3;
      lvl.p      <= pp_m[RECIP_LEVEL_SH +: LEVEL_W];
      lvl.q      <= pq_m[RECIP_FRAC_SH +: LEVEL_W];
      lvl.t      <= pt_m[RECIP_FRAC_SH +: LEVEL_W];
    end
  end

endmodule

FILE: rtl/core/hsv_to_rgb565_convert.sv
// HSV to RGB565 pixel converter.
// An accepted input moves through front, num, div, lvl and output registers.
// Throughput: one transaction per cycle; the pipeline stalls only when the
// output is not taken, and each stage holds its item until the next one frees.
// Reset (synchronous): clears all stage valid bits; payload registers keep data.
module hsv_to_rgb565_convert (
  input logic                 clk,
  input logic                 rst,
  hsv2rgb_in_if.sink          pix_in,
  hsv2rgb_out_if.source       pix_out
);
  import hsv2rgb_pkg::*;

  logic         num_valid;
  logic         num_ready;
  hsv2rgb_num_t num;
  logic         lvl_valid;
  logic         lvl_ready;
  hsv2rgb_lvl_t lvl;

  logic               valid5;
  logic [WORD_W-1:0]  word;
  logic [LEVEL_W-1:0] r_c;
  logic [LEVEL_W-1:0] g_c;
  logic [LEVEL_W-1:0] b_c;

  hsv2rgb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (pix_in.valid),
    .up_ready  (pix_in.ready),
    .hue_deg   (pix_in.hue_deg),
    .sat_level (pix_in.sat_level),
    .val_level (pix_in.val_level),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num)
  );

  hsv2rgb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num),
    .lvl_valid (lvl_valid),
    .lvl_ready (lvl_ready),
    .lvl       (lvl)
  );

  always_comb begin
    case (lvl.sector)
      SEC_RED_YEL: begin
        r_c = lvl.v; g_c = lvl.t; b_c = lvl.p;
      end
      SEC_YEL_GRN: begin
        r_c = lvl.q; g_c = lvl.v; b_c = lvl.p;
      end
      SEC_GRN_CYN: begin
        r_c = lvl.p; g_c = lvl.v; b_c = lvl.t;
      end
      SEC_CYN_BLU: begin
        r_c = lvl.p; g_c = lvl.q; b_c = lvl.v;
      end
      SEC_BLU_MAG: begin
        r_c = lvl.t; g_c = lvl.p; b_c = lvl.v;
      end
      default: begin
        r_c = lvl.v; g_c = lvl.p; b_c = lvl.q;
      end
    endcase
  end

  assign lvl_ready = !valid5 || pix_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid5 <= 1'b0;
    end else if (lvl_ready) begin
      valid5 <= lvl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_ready && lvl_valid) begin
      word <= {r_c[7:3], g_c[7:2], b_c[7:3]};
    end
  end

  assign pix_out.valid       = valid5;
  assign pix_out.rgb565_word = word;

endmodule
